@@ src/lifeg_pkg.sv @@
`timescale 1ns / 1ps

package lifeg_pkg;

    localparam int GRID_SIZE = 32;
    localparam int AW        = $clog2(GRID_SIZE);
    localparam int CW        = $clog2(GRID_SIZE);
    localparam int CNTW      = $clog2(GRID_SIZE + 3);

    localparam int ROW_W     = 5;
    localparam int COL_W     = 5;
    localparam int OP_W      = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    localparam logic [OP_W-1:0] OP_TOGGLE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP   = 2'd2;

    typedef logic [GRID_SIZE-1:0] t_row;

    typedef struct packed {
        logic alive;
        logic step_done;
    } t_res;

endpackage

@@ src/lifeg_ram.sv @@
`timescale 1ns / 1ps

module lifeg_ram #(
    parameter int W = 32,
    parameter int D = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/lifeg_rule.sv @@
`timescale 1ns / 1ps

module lifeg_rule (
    input  lifeg_pkg::t_row i_up,
    input  lifeg_pkg::t_row i_mid,
    input  lifeg_pkg::t_row i_dn,
    output lifeg_pkg::t_row o_next
);

    import lifeg_pkg::*;

    for (genvar c = 0; c < GRID_SIZE; c++) begin : g_cell
        localparam int CL = (c == 0) ? GRID_SIZE - 1 : c - 1;
        localparam int CR = (c == GRID_SIZE - 1) ? 0 : c + 1;
        logic [3:0] cnt;

        assign cnt = 4'(i_up[CL]) + 4'(i_up[c]) + 4'(i_up[CR])
                   + 4'(i_mid[CL]) + 4'(i_mid[CR])
                   + 4'(i_dn[CL]) + 4'(i_dn[c]) + 4'(i_dn[CR]);

        assign o_next[c] = (cnt == 4'd3) || (i_mid[c] && cnt == 4'd2);
    end

endmodule

@@ src/life_automaton_grid_core.sv @@
`timescale 1ns / 1ps
// Channel  | Dir | tdata (low bit up)            | tuser
// s_axis   | in  | row[4:0], col[9:5], zero pad  | op[1:0]
// m_axis   | out | alive[0], zero pad            | step_done[0]
//
// Toggle and read: memory read, modify and write-back (toggle only), result.
// Step reads one row per cycle through a three-row window and writes each
// new row back in row order, once its lower neighbor has been read.
// Reset clears the per-row valid flags; a row not yet written reads as dead.
// A result waiting on m_axis does not stop the next item from being taken.

module life_automaton_grid_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [lifeg_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // row, col
    input  logic [lifeg_pkg::OP_W-1:0]       s_axis_tuser,  // op
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [lifeg_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // alive
    output logic                             m_axis_tuser   // step_done
);

    import lifeg_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RMW  = 2'd1;
    localparam logic [1:0] S_STEP = 2'd2;
    localparam logic [1:0] S_PUT  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNTW-1:0]  r_cnt, n_cnt;
    logic [OP_W-1:0]  r_op;
    logic [AW-1:0]    r_row;
    logic [CW-1:0]    r_col;
    logic             r_ingrid;
    logic [AW-1:0]    r_raddr;
    logic [GRID_SIZE-1:0] r_valid;
    t_row             r_up, r_mid, r_row0;
    t_res             r_res, n_res;
    logic             r_mvalid;
    t_res             r_mres;

    logic             in_acc;
    logic [ROW_W-1:0] in_row;
    logic [COL_W-1:0] in_col;
    logic             we;
    logic [AW-1:0]    waddr, raddr;
    t_row             wdata, rdata, rdv, below, nxt;
    logic             cur_bit;
    logic             out_free;

    assign in_row        = s_axis_tdata[ROW_W-1:0];
    assign in_col        = s_axis_tdata[ROW_W+COL_W-1:ROW_W];
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_mvalid || m_axis_tready;

    assign rdv     = r_valid[r_raddr] ? rdata : '0;
    assign cur_bit = rdv[r_col];
    assign below   = (r_cnt == CNTW'(GRID_SIZE + 2)) ? r_row0 : rdv;

    lifeg_ram #(
        .W (GRID_SIZE),
        .D (GRID_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    lifeg_rule u_rule (
        .i_up   (r_up),
        .i_mid  (r_mid),
        .i_dn   (below),
        .o_next (nxt)
    );

    always_comb begin
        raddr = '0;
        we    = 1'b0;
        waddr = r_row;
        wdata = nxt;
        n_state = r_state;
        n_cnt   = r_cnt;
        n_res   = r_res;
        case (r_state)
            S_IDLE: begin
                raddr = AW'(in_row);
                n_cnt = '0;
                if (in_acc) begin
                    n_state = (s_axis_tuser == OP_STEP) ? S_STEP : S_RMW;
                end
            end
            S_RMW: begin
                we    = (r_op == OP_TOGGLE) && r_ingrid;
                wdata = rdv ^ (t_row'(1) << r_col);
                n_res.step_done = 1'b0;
                if (!r_ingrid) begin
                    n_res.alive = 1'b0;
                end else if (r_op == OP_TOGGLE) begin
                    n_res.alive = !cur_bit;
                end else if (r_op == OP_READ) begin
                    n_res.alive = cur_bit;
                end else begin
                    n_res.alive = 1'b0;
                end
                n_state = S_PUT;
            end
            S_STEP: begin
                raddr = (r_cnt == '0) ? AW'(GRID_SIZE - 1) : AW'(r_cnt - CNTW'(1));
                we    = (r_cnt >= CNTW'(3));
                waddr = AW'(r_cnt - CNTW'(3));
                wdata = nxt;
                n_cnt = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(GRID_SIZE + 2)) begin
                    n_res.alive     = 1'b0;
                    n_res.step_done = 1'b1;
                    n_state         = S_PUT;
                end
            end
            S_PUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_valid  <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (we) begin
                r_valid[waddr] <= 1'b1;
            end
            if (r_state == S_PUT && out_free) begin
                r_mvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_raddr <= raddr;
        r_res   <= n_res;
        if (in_acc) begin
            r_op     <= s_axis_tuser;
            r_row    <= AW'(in_row);
            r_col    <= CW'(in_col);
            r_ingrid <= (32'(in_row) < 32'(GRID_SIZE)) && (32'(in_col) < 32'(GRID_SIZE));
        end
        if (r_state == S_STEP && r_cnt != '0) begin
            r_up  <= r_mid;
            r_mid <= rdv;
            if (r_cnt == CNTW'(2)) begin
                r_row0 <= rdv;
            end
        end
        if (r_state == S_PUT && out_free) begin
            r_mres <= r_res;
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = M_TDATA_W'(r_mres.alive);
    assign m_axis_tuser  = r_mres.step_done;

endmodule

@@ src/lifeg_chk.sv @@
`timescale 1ns / 1ps

module lifeg_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [lifeg_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input logic [lifeg_pkg::OP_W-1:0]       s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [lifeg_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic                             m_axis_tuser
);

    import lifeg_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output item changed while stalled");

    a_step_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[0])
        else $error("step result reports a live cell");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while one is in work");

    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_STEP |=> ##2 !s_axis_tready)
        else $error("step finished too early");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:1] == '0)
        else $error("pad bits set in output item");

endmodule

bind life_automaton_grid_core lifeg_chk u_lifeg_chk (.*);
